// ===== hw/rtl/ctt_pkg.sv =====
package ctt_pkg;

  typedef enum logic [1:0] {
    ACT_DETECT = 2'd0,
    ACT_FRAME  = 2'd1,
    ACT_CLEAR  = 2'd2,
    ACT_NONE   = 2'd3
  } action_e;

  localparam int unsigned CfgIdxBits = 2;
  localparam logic [CfgIdxBits-1:0] CFG_LOST_LIMIT = 2'd0;
  localparam logic [CfgIdxBits-1:0] CFG_RADIUS_SQ  = 2'd1;
  localparam logic [CfgIdxBits-1:0] CFG_CONFIRM    = 2'd2;

  localparam int unsigned CfgDataBits = 22;
  localparam int unsigned CntBits     = 4;
  localparam int unsigned IdentBits   = 16;
  localparam int unsigned InCoordBits = 12;

  localparam logic [CntBits-1:0]     LostLimitReset = 4'd2;
  localparam logic [CfgDataBits-1:0] RadiusSqReset  = 22'd3600;
  localparam logic [CntBits-1:0]     ConfirmReset   = 4'd2;

  // back state machine
  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SCAN  = 5'b00010,
    ST_PLACE = 5'b00100,
    ST_AGE   = 5'b01000,
    ST_EMIT  = 5'b10000
  } back_state_e;

endpackage

// ===== hw/rtl/ctt_queue.sv =====
// short fifo between front and back
module ctt_queue #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] pop_data_o,
  output logic             empty_o
);
  localparam int unsigned PtrBits = (Depth > 1) ? $clog2(Depth) : 1;

  logic [Width-1:0]   mem_q [Depth];
  logic [PtrBits-1:0] wr_q, rd_q;
  logic [PtrBits:0]   cnt_q;

  assign full_o     = (cnt_q == (PtrBits+1)'(Depth));
  assign empty_o    = (cnt_q == '0);
  assign pop_data_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i && !full_o) begin
        wr_q <= (wr_q == PtrBits'(Depth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i && !empty_o) begin
        rd_q <= (rd_q == PtrBits'(Depth - 1)) ? '0 : rd_q + 1'b1;
      end
      cnt_q <= cnt_q + (PtrBits+1)'(push_i && !full_o) - (PtrBits+1)'(pop_i && !empty_o);
    end
  end

  // checks
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   cnt_q <= (PtrBits+1)'(Depth))
    else $error("queue count above depth");
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(full_o && empty_o))
    else $error("queue full and empty at once");
  assert property (@(posedge clk_i) disable iff (!rst_ni) push_i |-> !full_o)
    else $error("push into full queue");
endmodule

// ===== hw/rtl/ctt_front.sv =====
// accepts transactions, drops meaningless actions, packs queue entries
module ctt_front #(
  parameter int unsigned CoordBits = 12
) (
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [1:0]              action_i,
  input  logic [CoordBits-1:0]    center_x_i,
  input  logic [CoordBits-1:0]    center_y_i,
  input  logic                    q_full_i,
  output logic                    q_push_o,
  output logic [2*CoordBits+1:0]  q_data_o
);
  logic keep;

  // action 3 is taken and dropped here
  assign keep       = (ctt_pkg::action_e'(action_i) != ctt_pkg::ACT_NONE);
  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i && keep;
  assign q_data_o   = {action_i, center_x_i, center_y_i};
endmodule

// ===== hw/rtl/ctt_back.sv =====
// track table engine: one slot per cycle for scan and age, and for emit while the output is not stalled
module ctt_back #(
  parameter int unsigned TrackSlots = 16,
  parameter int unsigned CoordBits  = 12
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ctt_pkg::CfgIdxBits-1:0] cfg_idx_i,
  input  logic [ctt_pkg::CfgDataBits-1:0] cfg_data_i,
  input  logic                          q_empty_i,
  input  logic [2*CoordBits+1:0]        q_data_i,
  output logic                          q_pop_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          track_present_o,
  output logic [ctt_pkg::IdentBits-1:0] track_id_o,
  output logic [CoordBits-1:0]          track_x_o,
  output logic [CoordBits-1:0]          track_y_o,
  output logic [ctt_pkg::CntBits-1:0]   missed_frames_o,
  output logic [ctt_pkg::CntBits-1:0]   hit_count_o,
  output logic                          table_overflow_o,
  output logic                          last_of_frame_o
);
  localparam int unsigned SlotBits = $clog2(TrackSlots);
  localparam int unsigned SqBits   = 2 * CoordBits + 1;
  localparam int unsigned CntW     = ctt_pkg::CntBits;

  // configuration
  logic [CntW-1:0]                 lost_limit_q, confirm_q;
  logic [ctt_pkg::CfgDataBits-1:0] radius_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lost_limit_q <= ctt_pkg::LostLimitReset;
      radius_q     <= ctt_pkg::RadiusSqReset;
      confirm_q    <= ctt_pkg::ConfirmReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ctt_pkg::CFG_LOST_LIMIT: lost_limit_q <= cfg_data_i[CntW-1:0];
        ctt_pkg::CFG_RADIUS_SQ:  radius_q     <= cfg_data_i;
        ctt_pkg::CFG_CONFIRM:    confirm_q    <= cfg_data_i[CntW-1:0];
        default: ;
      endcase
    end
  end

  // slot payload store
  logic [CoordBits-1:0]          sx_q [TrackSlots];
  logic [CoordBits-1:0]          sy_q [TrackSlots];
  logic [CntW-1:0]               smiss_q [TrackSlots];
  logic [CntW-1:0]               shits_q [TrackSlots];
  logic [ctt_pkg::IdentBits-1:0] sid_q [TrackSlots];
  logic [TrackSlots-1:0]         used_q, matched_q, born_q;
  logic [ctt_pkg::IdentBits-1:0] next_id_q;
  logic                          ovf_q;

  ctt_pkg::back_state_e state_q;
  logic [SlotBits-1:0]  idx_q;
  logic [CoordBits-1:0] cx_q, cy_q;
  logic                 best_vld_q;
  logic [SlotBits-1:0]  best_q;
  logic [SqBits-1:0]    best_d_q;
  logic                 any_emit_q, ovf_frame_q;

  // output register
  logic                          ov_q, pres_q, last_q, oovf_q, lastmark_q;
  logic [ctt_pkg::IdentBits-1:0] oid_q;
  logic [CoordBits-1:0]          ox_q, oy_q;
  logic [CntW-1:0]               omiss_q, ohits_q;

  logic out_free;
  assign out_free = !ov_q || !out_stall_i;

  // distance of current slot to the held center
  logic [CoordBits-1:0]   dx, dy;
  logic [2*CoordBits-1:0] dx_sq, dy_sq;
  logic [SqBits-1:0]      sq_dist;
  logic                   cand, closer;
  assign dx      = (cx_q > sx_q[idx_q]) ? cx_q - sx_q[idx_q] : sx_q[idx_q] - cx_q;
  assign dy      = (cy_q > sy_q[idx_q]) ? cy_q - sy_q[idx_q] : sy_q[idx_q] - cy_q;
  assign dx_sq   = dx * dx;
  assign dy_sq   = dy * dy;
  assign sq_dist = {1'b0, dx_sq} + {1'b0, dy_sq};
  assign cand    = used_q[idx_q] && !matched_q[idx_q] && !born_q[idx_q];
  assign closer  = best_vld_q ? (sq_dist < best_d_q)
                              : ({1'b0, sq_dist} < (SqBits+1)'(radius_q));

  // lowest free slot
  logic                free_vld;
  logic [SlotBits-1:0] free_idx;
  always_comb begin
    free_vld = 1'b0;
    free_idx = '0;
    for (int i = TrackSlots - 1; i >= 0; i--) begin
      if (!used_q[i]) begin
        free_vld = 1'b1;
        free_idx = SlotBits'(i);
      end
    end
  end

  logic last_idx, emit_hit, emit_now;
  logic [CntW:0] miss_inc, hit_inc;
  assign last_idx = (idx_q == SlotBits'(TrackSlots - 1));
  assign emit_hit = used_q[idx_q] && (shits_q[idx_q] >= confirm_q);
  assign miss_inc = {1'b0, smiss_q[idx_q]} + 1'b1;
  assign hit_inc  = {1'b0, shits_q[best_q]} + 1'b1;
  // a slot emits if confirmed; the last slot also emits an empty result when nothing was emitted in the frame
  assign emit_now = (state_q == ctt_pkg::ST_EMIT) && out_free &&
                    (emit_hit || (last_idx && !any_emit_q));

  assign q_pop_o = (state_q == ctt_pkg::ST_IDLE) && !q_empty_i;

  always_ff @(posedge clk_i) begin
    if (state_q == ctt_pkg::ST_PLACE) begin
      if (best_vld_q) begin
        sx_q[best_q]    <= cx_q;
        sy_q[best_q]    <= cy_q;
        smiss_q[best_q] <= '0;
        shits_q[best_q] <= (hit_inc > {1'b0, confirm_q}) ? confirm_q : hit_inc[CntW-1:0];
      end else if (free_vld) begin
        sx_q[free_idx]    <= cx_q;
        sy_q[free_idx]    <= cy_q;
        smiss_q[free_idx] <= '0;
        shits_q[free_idx] <= '0;
        sid_q[free_idx]   <= next_id_q;
      end
    end
    if (state_q == ctt_pkg::ST_AGE && cand && (miss_inc < {1'b0, lost_limit_q})) begin
      smiss_q[idx_q] <= miss_inc[CntW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ctt_pkg::ST_IDLE && !q_empty_i) begin
      cx_q <= q_data_i[2*CoordBits-1:CoordBits];
      cy_q <= q_data_i[CoordBits-1:0];
    end
    if (state_q == ctt_pkg::ST_SCAN && cand && closer) begin
      best_q   <= idx_q;
      best_d_q <= sq_dist;
    end
    if (emit_now) begin
      if (emit_hit) begin
        oid_q   <= sid_q[idx_q];
        ox_q    <= sx_q[idx_q];
        oy_q    <= sy_q[idx_q];
        omiss_q <= smiss_q[idx_q];
        ohits_q <= shits_q[idx_q];
      end else begin
        oid_q   <= '0;
        ox_q    <= '0;
        oy_q    <= '0;
        omiss_q <= '0;
        ohits_q <= '0;
      end
    end
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ctt_pkg::ST_IDLE;
      idx_q       <= '0;
      best_vld_q  <= 1'b0;
      used_q      <= '0;
      matched_q   <= '0;
      born_q      <= '0;
      next_id_q   <= '0;
      ovf_q       <= 1'b0;
      any_emit_q  <= 1'b0;
      ovf_frame_q <= 1'b0;
      ov_q        <= 1'b0;
      pres_q      <= 1'b0;
      last_q      <= 1'b0;
      oovf_q      <= 1'b0;
    end else begin
      if (emit_now) begin
        ov_q   <= 1'b1;
        pres_q <= emit_hit;
        oovf_q <= ovf_frame_q;
        last_q <= last_idx;
      end else if (ov_q && !out_stall_i) begin
        ov_q <= 1'b0;
      end
      case (state_q)
        ctt_pkg::ST_IDLE: begin
          if (!q_empty_i) begin
            idx_q      <= '0;
            best_vld_q <= 1'b0;
            case (ctt_pkg::action_e'(q_data_i[2*CoordBits+1:2*CoordBits]))
              ctt_pkg::ACT_DETECT: state_q <= ctt_pkg::ST_SCAN;
              ctt_pkg::ACT_FRAME: begin
                state_q     <= ctt_pkg::ST_AGE;
                ovf_frame_q <= ovf_q;
                any_emit_q  <= 1'b0;
              end
              ctt_pkg::ACT_CLEAR: begin
                used_q    <= '0;
                matched_q <= '0;
                born_q    <= '0;
                next_id_q <= '0;
                ovf_q     <= 1'b0;
              end
              default: ;
            endcase
          end
        end
        ctt_pkg::ST_SCAN: begin
          if (cand && closer) begin
            best_vld_q <= 1'b1;
          end
          idx_q <= last_idx ? '0 : idx_q + 1'b1;
          if (last_idx) begin
            state_q <= ctt_pkg::ST_PLACE;
          end
        end
        ctt_pkg::ST_PLACE: begin
          if (best_vld_q) begin
            matched_q[best_q] <= 1'b1;
          end else if (free_vld) begin
            used_q[free_idx] <= 1'b1;
            born_q[free_idx] <= 1'b1;
            next_id_q        <= next_id_q + 1'b1;
          end else begin
            ovf_q <= 1'b1;
          end
          state_q <= ctt_pkg::ST_IDLE;
        end
        ctt_pkg::ST_AGE: begin
          if (cand && !(miss_inc < {1'b0, lost_limit_q})) begin
            used_q[idx_q] <= 1'b0;
          end
          matched_q[idx_q] <= 1'b0;
          born_q[idx_q]    <= 1'b0;
          idx_q <= last_idx ? '0 : idx_q + 1'b1;
          if (last_idx) begin
            ovf_q   <= 1'b0;
            state_q <= ctt_pkg::ST_EMIT;
          end
        end
        ctt_pkg::ST_EMIT: begin
          if (out_free) begin
            if (emit_hit) begin
              any_emit_q <= 1'b1;
            end
            idx_q <= last_idx ? '0 : idx_q + 1'b1;
            if (last_idx) begin
              state_q <= ctt_pkg::ST_IDLE;
            end
          end
        end
        default: state_q <= ctt_pkg::ST_IDLE;
      endcase
    end
  end

  // a confirmed track before the last slot is the last result when no later one follows
  logic [TrackSlots-1:0] conf_vec;
  logic                  later_conf;
  always_comb begin
    for (int i = 0; i < TrackSlots; i++) begin
      conf_vec[i] = used_q[i] && (shits_q[i] >= confirm_q);
    end
    later_conf = |(conf_vec >> (32'(idx_q) + 1));
  end

  assign out_valid_o      = ov_q;
  assign track_present_o  = pres_q;
  assign track_id_o       = oid_q;
  assign track_x_o        = ox_q;
  assign track_y_o        = oy_q;
  assign missed_frames_o  = omiss_q;
  assign hit_count_o      = ohits_q;
  assign table_overflow_o = oovf_q;
  assign last_of_frame_o  = last_q || (ov_q && pres_q && lastmark_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lastmark_q <= 1'b0;
    end else if (state_q == ctt_pkg::ST_EMIT && out_free && emit_hit) begin
      lastmark_q <= !later_conf;
    end
  end

  // checks
  assert property (@(posedge clk_i) disable iff (!rst_ni) (matched_q & born_q) == '0)
    else $error("slot both matched and born");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   ((matched_q | born_q) & ~used_q) == '0)
    else $error("flag on free slot");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   !(ov_q && !pres_q && !last_of_frame_o))
    else $error("empty frame result without last marker");
endmodule

// ===== hw/rtl/centroid_track_table_top.sv =====
// channel   direction  payload
// in        input      action_i, center_x_i, center_y_i
// out       output     track_present_o .. last_of_frame_o
// cfg       input      cfg_we_i, cfg_idx_i, cfg_data_i
//
// a detection runs in the back engine as a scan (one slot compare per cycle), then a place step
// an end of frame runs aging then emit in the back engine; emit waits on output stall
// a clear is done by the back engine in its idle state; a meaningless action is dropped by the front
// a two-entry queue lets the front accept while the back works
// reset clears the slot valid bits, the next id and the overflow flag at once
module centroid_track_table_top #(
  parameter int unsigned TrackSlots = 16,
  parameter int unsigned CoordBits  = 12
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [ctt_pkg::CfgIdxBits-1:0]  cfg_idx_i,
  input  logic [ctt_pkg::CfgDataBits-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [1:0]                      action_i,
  input  logic [CoordBits-1:0]            center_x_i,
  input  logic [CoordBits-1:0]            center_y_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            track_present_o,
  output logic [ctt_pkg::IdentBits-1:0]   track_id_o,
  output logic [CoordBits-1:0]            track_x_o,
  output logic [CoordBits-1:0]            track_y_o,
  output logic [ctt_pkg::CntBits-1:0]     missed_frames_o,
  output logic [ctt_pkg::CntBits-1:0]     hit_count_o,
  output logic                            table_overflow_o,
  output logic                            last_of_frame_o
);
  localparam int unsigned QW = 2 * CoordBits + 2;

  logic          q_push, q_full, q_pop, q_empty;
  logic [QW-1:0] q_wdata, q_rdata;

  ctt_front #(.CoordBits(CoordBits)) u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .action_i   (action_i),
    .center_x_i (center_x_i),
    .center_y_i (center_y_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_data_o   (q_wdata)
  );

  ctt_queue #(.Width(QW), .Depth(2)) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_wdata),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .pop_data_o  (q_rdata),
    .empty_o     (q_empty)
  );

  ctt_back #(.TrackSlots(TrackSlots), .CoordBits(CoordBits)) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .q_empty_i        (q_empty),
    .q_data_i         (q_rdata),
    .q_pop_o          (q_pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .track_present_o  (track_present_o),
    .track_id_o       (track_id_o),
    .track_x_o        (track_x_o),
    .track_y_o        (track_y_o),
    .missed_frames_o  (missed_frames_o),
    .hit_count_o      (hit_count_o),
    .table_overflow_o (table_overflow_o),
    .last_of_frame_o  (last_of_frame_o)
  );
endmodule
